/* src/tvag_pkg.sv */
// tvag_pkg: shared types, constants and register codes for the tensor view address generator
// depends on nothing; imported by every module under src except tvag_ram

package tvag_pkg;

    // fixed layout of the packed configuration registers and item fields
    localparam int PACKED_DIMS = 4;
    localparam int IDX_W       = 9;
    localparam int EXT_W       = 9;
    localparam int MODE_W      = 10;
    localparam int PERM_W      = 2;
    localparam int FDIM_W      = 2;
    localparam int FSLOT_W     = 8;
    localparam int FVAL_W      = 8;
    localparam int OFFS_W      = 32;
    localparam int ND_W        = 3;

    // clamps applied to dimension count and extents
    localparam int MAX_DIMS    = 4;
    localparam int MAX_EXTENT  = 256;
    localparam int ND_CAP      = (MAX_DIMS < PACKED_DIMS) ? MAX_DIMS : PACKED_DIMS;

    // default filter table depth per dimension
    localparam int FILTER_DEPTH_DEF = 256;

    // apb register file
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_DIMS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_EXTENTS     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INDEX_MODES = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PERMUTATION = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FILTER_LENS = 3'd4;

    localparam logic [ND_W-1:0]             ACTIVE_DIMS_RST = 3'd1;
    localparam logic [PACKED_DIMS*EXT_W-1:0] EXTENTS_RST    = 36'd134480385;
    localparam logic [PACKED_DIMS*MODE_W-1:0] MODES_RST     = '0;
    localparam logic [PACKED_DIMS*PERM_W-1:0] PERM_RST      = 8'd228;
    localparam logic [PACKED_DIMS*EXT_W-1:0] FLENS_RST      = '0;

    // item commands
    localparam logic CMD_COMPUTE   = 1'b0;
    localparam logic CMD_FILTER_WR = 1'b1;

    typedef struct packed {
        logic               command;
        logic [IDX_W-1:0]   index_a;
        logic [IDX_W-1:0]   index_b;
        logic [IDX_W-1:0]   index_c;
        logic [IDX_W-1:0]   index_d;
        logic [FDIM_W-1:0]  filter_dim;
        logic [FSLOT_W-1:0] filter_slot;
        logic [FVAL_W-1:0]  filter_value;
    } in_item_t;

    typedef struct packed {
        logic [OFFS_W-1:0] offset;
        logic              range_error;
    } out_item_t;

    // decoded role of one dimension
    typedef enum logic [1:0] {
        DIM_FREE,
        DIM_FIXED,
        DIM_TIE,
        DIM_BAD
    } dim_kind_t;

    typedef struct packed {
        dim_kind_t         kind;
        logic [PERM_W-1:0] sel;      // free input feeding this dimension
        logic [FDIM_W-1:0] src;      // tie source dimension
        logic [IDX_W-1:0]  fixed_l;  // 0-based fixed index
        logic [EXT_W-1:0]  ext;      // clamped extent
        logic [EXT_W-1:0]  flen;     // clamped filter length
    } dim_cfg_t;

    typedef struct packed {
        logic [ND_W-1:0]                nd;
        dim_cfg_t [PACKED_DIMS-1:0]     dim;
    } view_cfg_t;

    // per-dimension 0-based indices between mapping and accumulation
    typedef struct packed {
        logic [PACKED_DIMS-1:0][IDX_W-1:0] l;
        logic                              err;
    } lane_item_t;

endpackage

/* src/tvag_ram.sv */
// tvag_ram: generic single-port-write, single-port-read ram with registered read
// depends on nothing

module tvag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/tvag_cfg.sv */
// tvag_cfg: apb register file and static decode of the view configuration
// depends on tvag_pkg

module tvag_cfg
    import tvag_pkg::*;
#(
    parameter int FILTER_DEPTH = FILTER_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output view_cfg_t          view
);

    logic [ND_W-1:0]                active_reg;
    logic [PACKED_DIMS*EXT_W-1:0]   extents_reg;
    logic [PACKED_DIMS*MODE_W-1:0]  modes_reg;
    logic [PACKED_DIMS*PERM_W-1:0]  perm_reg;
    logic [PACKED_DIMS*EXT_W-1:0]   flens_reg;

    logic                  wr_stb;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [MODE_W-1:0]     mode_raw [PACKED_DIMS];

    assign pready  = 1'b1;
    assign wr_stb  = psel & penable & pwrite;
    assign reg_idx = paddr[PADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= ACTIVE_DIMS_RST;
            extents_reg <= EXTENTS_RST;
            modes_reg   <= MODES_RST;
            perm_reg    <= PERM_RST;
            flens_reg   <= FLENS_RST;
        end
        else if (wr_stb)
        begin
            case (reg_idx)
                REG_ACTIVE_DIMS: active_reg  <= pwdata[ND_W-1:0];
                REG_EXTENTS:     extents_reg <= pwdata[PACKED_DIMS*EXT_W-1:0];
                REG_INDEX_MODES: modes_reg   <= pwdata[PACKED_DIMS*MODE_W-1:0];
                REG_PERMUTATION: perm_reg    <= pwdata[PACKED_DIMS*PERM_W-1:0];
                REG_FILTER_LENS: flens_reg   <= pwdata[PACKED_DIMS*EXT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ACTIVE_DIMS: prdata = PDATA_W'(active_reg);
            REG_EXTENTS:     prdata = PDATA_W'(extents_reg);
            REG_INDEX_MODES: prdata = PDATA_W'(modes_reg);
            REG_PERMUTATION: prdata = PDATA_W'(perm_reg);
            REG_FILTER_LENS: prdata = PDATA_W'(flens_reg);
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        for (int d = 0; d < PACKED_DIMS; d++)
        begin
            mode_raw[d] = modes_reg[MODE_W*d +: MODE_W];
        end
    end

    // decode each dimension: free slot order, tie legality, clamps
    always_comb
    begin
        logic [MODE_W-1:0] raw;
        logic [MODE_W:0]   k;
        logic [1:0]        slot;
        logic [EXT_W-1:0]  e;
        logic [EXT_W-1:0]  fl;

        slot    = '0;
        view    = '0;
        view.nd = (32'(active_reg) > ND_CAP) ? ND_W'(ND_CAP) : active_reg;
        for (int d = 0; d < PACKED_DIMS; d++)
        begin
            raw = mode_raw[d];
            k   = (MODE_W+1)'(1 << MODE_W) - {1'b0, raw};
            e   = extents_reg[EXT_W*d +: EXT_W];
            fl  = flens_reg[EXT_W*d +: EXT_W];

            view.dim[d].ext  = (32'(e) > MAX_EXTENT) ? EXT_W'(MAX_EXTENT) : e;
            view.dim[d].flen = (32'(fl) > FILTER_DEPTH) ? EXT_W'(FILTER_DEPTH) : fl;

            if (raw == '0)
            begin
                view.dim[d].kind = DIM_FREE;
                view.dim[d].sel  = perm_reg[PERM_W*slot +: PERM_W];
                slot             = slot + 2'd1;
            end
            else if (raw[MODE_W-1])
            begin
                // tie: target must be in range and itself free
                if (k > (MODE_W+1)'(view.nd))
                begin
                    view.dim[d].kind = DIM_BAD;
                end
                else if (mode_raw[FDIM_W'(k - (MODE_W+1)'(1))] != '0)
                begin
                    view.dim[d].kind = DIM_BAD;
                end
                else
                begin
                    view.dim[d].kind = DIM_TIE;
                    view.dim[d].src  = FDIM_W'(k - (MODE_W+1)'(1));
                end
            end
            else
            begin
                view.dim[d].kind    = DIM_FIXED;
                view.dim[d].fixed_l = IDX_W'(raw - MODE_W'(1));
            end
        end
    end

endmodule

/* src/tvag_map.sv */
// tvag_map: filter table rams and per-dimension index mapping (two pipeline stages)
// depends on tvag_pkg and tvag_ram

module tvag_map
    import tvag_pkg::*;
#(
    parameter int FILTER_DEPTH = FILTER_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  view_cfg_t  view,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  in_item_t   cmd_item,
    output logic       lane_valid,
    input  logic       lane_ready,
    output lane_item_t lane_item
);

    localparam int FA_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;

    logic                               s1_valid_reg;
    logic                               s1_write_reg;
    logic [PACKED_DIMS-1:0][IDX_W-1:0]  s1_j_reg;
    logic                               s2_valid_reg;
    lane_item_t                         s2_item_reg;

    logic                               s1_ready;
    logic                               s2_ready;
    logic                               take;
    logic                               slot_ok;
    logic [PACKED_DIMS-1:0][IDX_W-1:0]  j_s0;
    logic [PACKED_DIMS-1:0][FVAL_W-1:0] rd_data;
    lane_item_t                         s2_next;

    function automatic logic [IDX_W-1:0] pick_index(in_item_t it, logic [PERM_W-1:0] sel);
        logic [IDX_W-1:0] v;
        case (sel)
            2'd0:    v = it.index_a;
            2'd1:    v = it.index_b;
            2'd2:    v = it.index_c;
            default: v = it.index_d;
        endcase
        return v;
    endfunction

    assign s2_ready  = !s2_valid_reg | lane_ready;
    assign s1_ready  = !s1_valid_reg | s2_ready;
    assign cmd_ready = s1_ready;
    assign take      = cmd_valid & s1_ready;
    assign slot_ok   = 32'(cmd_item.filter_slot) < FILTER_DEPTH;

    always_comb
    begin
        for (int d = 0; d < PACKED_DIMS; d++)
        begin
            j_s0[d] = pick_index(cmd_item, view.dim[d].sel);
        end
    end

    // one table per dimension, read at the 0-based position of its free index
    for (genvar d = 0; d < PACKED_DIMS; d++)
    begin : g_tab
        tvag_ram #(
            .WIDTH (FVAL_W),
            .DEPTH (FILTER_DEPTH)
        ) u_ram (
            .clk     (clk),
            .wr_en   (take && cmd_item.command == CMD_FILTER_WR
                      && cmd_item.filter_dim == FDIM_W'(d) && slot_ok),
            .wr_addr (FA_W'(cmd_item.filter_slot)),
            .wr_data (cmd_item.filter_value),
            .rd_en   (take && cmd_item.command == CMD_COMPUTE),
            .rd_addr (FA_W'(j_s0[d] - IDX_W'(1))),
            .rd_data (rd_data[d])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= cmd_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_write_reg <= cmd_item.command;
            s1_j_reg     <= j_s0;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_item_reg <= s2_next;
        end
    end

    // map each free index through its filter, resolve ties, check extents
    always_comb
    begin
        logic [PACKED_DIMS-1:0][IDX_W-1:0] lm;
        logic [PACKED_DIMS-1:0]            em;
        logic [IDX_W-1:0]                  jm1;
        logic [IDX_W-1:0]                  lv;
        logic                              ev;

        s2_next = '0;
        for (int d = 0; d < PACKED_DIMS; d++)
        begin
            jm1   = s1_j_reg[d] - IDX_W'(1);
            lm[d] = '0;
            em[d] = 1'b0;
            if (s1_j_reg[d] == '0)
            begin
                em[d] = 1'b1;
            end
            else if (view.dim[d].flen == '0)
            begin
                lm[d] = jm1;
            end
            else if (jm1 >= view.dim[d].flen)
            begin
                em[d] = 1'b1;
            end
            else
            begin
                lm[d] = IDX_W'(rd_data[d]);
            end
        end
        for (int d = 0; d < PACKED_DIMS; d++)
        begin
            case (view.dim[d].kind)
                DIM_FREE:
                begin
                    lv = lm[d];
                    ev = em[d];
                end
                DIM_TIE:
                begin
                    lv = lm[view.dim[d].src];
                    ev = em[view.dim[d].src];
                end
                DIM_FIXED:
                begin
                    lv = view.dim[d].fixed_l;
                    ev = 1'b0;
                end
                default:
                begin
                    lv = '0;
                    ev = 1'b1;
                end
            endcase
            if (lv >= view.dim[d].ext)
            begin
                ev = 1'b1;
            end
            if (ND_W'(d) < view.nd)
            begin
                s2_next.err = s2_next.err | ev;
            end
            s2_next.l[d] = lv;
        end
        // a filter write yields a zero offset and no error
        if (s1_write_reg == CMD_FILTER_WR)
        begin
            s2_next = '0;
        end
    end

    assign lane_valid = s2_valid_reg;
    assign lane_item  = s2_item_reg;

endmodule

/* src/tvag_acc.sv */
// tvag_acc: row-major multiply-accumulate over the dimensions, one multiply per stage
// depends on tvag_pkg

module tvag_acc
    import tvag_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  view_cfg_t  view,
    input  logic       lane_valid,
    output logic       lane_ready,
    input  lane_item_t lane_item,
    output logic       addr_valid,
    input  logic       addr_ready,
    output out_item_t  addr_item
);

    logic              a_valid_reg;
    logic              b_valid_reg;
    logic              c_valid_reg;
    logic [OFFS_W-1:0] a_acc_reg;
    logic [IDX_W-1:0]  a_l2_reg;
    logic [IDX_W-1:0]  a_l3_reg;
    logic              a_err_reg;
    logic [OFFS_W-1:0] b_acc_reg;
    logic [IDX_W-1:0]  b_l3_reg;
    logic              b_err_reg;
    out_item_t         c_item_reg;

    logic              a_ready;
    logic              b_ready;
    logic              c_ready;
    logic [OFFS_W-1:0] first;
    logic [OFFS_W-1:0] a_acc_next;
    logic [OFFS_W-1:0] b_acc_next;
    logic [OFFS_W-1:0] c_acc_next;

    assign c_ready    = !c_valid_reg | addr_ready;
    assign b_ready    = !b_valid_reg | c_ready;
    assign a_ready    = !a_valid_reg | b_ready;
    assign lane_ready = a_ready;

    // dimensions beyond the active count leave the accumulator alone
    assign first      = (view.nd != '0) ? OFFS_W'(lane_item.l[0]) : '0;
    assign a_acc_next = (view.nd > ND_W'(1))
                        ? first * OFFS_W'(view.dim[1].ext) + OFFS_W'(lane_item.l[1])
                        : first;
    assign b_acc_next = (view.nd > ND_W'(2))
                        ? a_acc_reg * OFFS_W'(view.dim[2].ext) + OFFS_W'(a_l2_reg)
                        : a_acc_reg;
    assign c_acc_next = (view.nd > ND_W'(3))
                        ? b_acc_reg * OFFS_W'(view.dim[3].ext) + OFFS_W'(b_l3_reg)
                        : b_acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= lane_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane_valid && a_ready)
        begin
            a_acc_reg <= a_acc_next;
            a_l2_reg  <= lane_item.l[2];
            a_l3_reg  <= lane_item.l[3];
            a_err_reg <= lane_item.err;
        end
        if (a_valid_reg && b_ready)
        begin
            b_acc_reg <= b_acc_next;
            b_l3_reg  <= a_l3_reg;
            b_err_reg <= a_err_reg;
        end
        if (b_valid_reg && c_ready)
        begin
            c_item_reg.offset      <= b_err_reg ? '0 : c_acc_next;
            c_item_reg.range_error <= b_err_reg;
        end
    end

    assign addr_valid = c_valid_reg;
    assign addr_item  = c_item_reg;

endmodule

/* src/tensor_view_address_generator_top.sv */
// tensor_view_address_generator_top: apb configuration, filter tables and address pipeline
// depends on tvag_pkg, tvag_cfg, tvag_map, tvag_acc (and tvag_ram below tvag_map)
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+--------------------------------
//  apb       | in/out    | psel, penable, pready   | paddr, pwdata, pwrite / prdata
//  cmd       | in        | cmd_valid, cmd_ready    | cmd_item (in_item_t)
//  addr      | out       | addr_valid, addr_ready  | addr_item (out_item_t)
//
// one item per clock sustained while addr_ready is high; five register stages (map stages s1
// and s2, accumulate stages a, b and c), with addr_valid driven from the last of them
// the stages are the filter ram registered read, the mapping stage and the
// three-stage multiply-accumulate chain (one 32x9 multiply per stage)
// reset clears the configuration registers to their defaults and empties the
// pipeline; filter tables are not cleared and hold garbage until written
// each stage takes a new item when it is empty or its successor moves, so
// bubbles close up under a stalled output and no item is dropped or repeated

module tensor_view_address_generator_top
    import tvag_pkg::*;
#(
    parameter int FILTER_DEPTH = FILTER_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // apb configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // command items
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  in_item_t           cmd_item,
    // address results
    output logic               addr_valid,
    input  logic               addr_ready,
    output out_item_t          addr_item
);

    // decoded view; the user must keep it static while items flow, the block does not enforce it
    view_cfg_t  view;

    // mapped indices between the mapping and accumulate sections
    logic       lane_valid;
    logic       lane_ready;
    lane_item_t lane_item;

    tvag_cfg #(
        .FILTER_DEPTH (FILTER_DEPTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .view    (view)
    );

    // filter writes and index mapping
    tvag_map #(
        .FILTER_DEPTH (FILTER_DEPTH)
    ) u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .view       (view),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_item   (cmd_item),
        .lane_valid (lane_valid),
        .lane_ready (lane_ready),
        .lane_item  (lane_item)
    );

    // row-major combination, dimension 0 most significant
    tvag_acc u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .view       (view),
        .lane_valid (lane_valid),
        .lane_ready (lane_ready),
        .lane_item  (lane_item),
        .addr_valid (addr_valid),
        .addr_ready (addr_ready),
        .addr_item  (addr_item)
    );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// testbench: self-checking bench for tensor_view_address_generator_top
// depends on tvag_pkg and the rtl under src; reads no files, needs no arguments

module testbench;
    import tvag_pkg::*;

    // no accepted item in this many cycles means the block has hung
    localparam int QUIET_LIMIT  = 4000;
    // stop adding random phases once this many items are queued
    localparam int ITEM_TARGET  = 1550;
    // pipeline is five deep, so this covers anything still in flight
    localparam int DRAIN_CYCLES = 10;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    in_item_t           cmd_item = '0;
    logic               addr_valid;
    logic               addr_ready = 1'b0;
    out_item_t          addr_item;

    tensor_view_address_generator_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_item   (cmd_item),
        .addr_valid (addr_valid),
        .addr_ready (addr_ready),
        .addr_item  (addr_item)
    );

    // our copy of the view registers, kept in step with every apb write
    logic [ND_W-1:0]                nd_q   = ACTIVE_DIMS_RST;
    logic [PACKED_DIMS*EXT_W-1:0]   ext_q  = EXTENTS_RST;
    logic [PACKED_DIMS*MODE_W-1:0]  mode_q = MODES_RST;
    logic [PACKED_DIMS*PERM_W-1:0]  perm_q = PERM_RST;
    logic [PACKED_DIMS*EXT_W-1:0]   flen_q = FLENS_RST;

    // our copy of the filter tables, written as write items are accepted
    bit [FVAL_W-1:0] filter_mem [PACKED_DIMS][FILTER_DEPTH_DEF];
    // slots that some queued write item will have filled before any read
    bit              slot_planned [PACKED_DIMS][FILTER_DEPTH_DEF];

    in_item_t  cmd_backlog[$];      // items waiting for the driver
    out_item_t predicted_addrs[$];  // results owed by the block, oldest first

    int   items_queued = 0;
    int   mismatch_count = 0;
    int   quiet_cycles = 0;
    int   sender_idle_pct = 25;
    int   receiver_stall_pct = 65;
    logic cmd_fired = 1'b0;

    initial begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // view decoding shared by the predictor and the item generator
    // ------------------------------------------------------------------

    function automatic int unsigned mode_field(int unsigned d);
        return 32'(mode_q[MODE_W*d +: MODE_W]);
    endfunction

    // extents above MAX_EXTENT saturate
    function automatic int unsigned extent_eff(int unsigned d);
        int unsigned e;
        e = 32'(ext_q[EXT_W*d +: EXT_W]);
        return (e > MAX_EXTENT) ? MAX_EXTENT : e;
    endfunction

    // filter lengths above the table depth saturate; zero means identity
    function automatic int unsigned flen_eff(int unsigned d);
        int unsigned n;
        n = 32'(flen_q[EXT_W*d +: EXT_W]);
        return (n > FILTER_DEPTH_DEF) ? FILTER_DEPTH_DEF : n;
    endfunction

    function automatic int unsigned dims_eff();
        return (32'(nd_q) > ND_CAP) ? ND_CAP : 32'(nd_q);
    endfunction

    // ------------------------------------------------------------------
    // address predictor
    // ------------------------------------------------------------------

    // which of the four free inputs feeds the n-th free dimension
    function automatic int unsigned pick_input(in_item_t it, int unsigned n);
        case (perm_q[PERM_W*(n % PACKED_DIMS) +: PERM_W])
            2'd0:    return 32'(it.index_a);
            2'd1:    return 32'(it.index_b);
            2'd2:    return 32'(it.index_c);
            default: return 32'(it.index_d);
        endcase
    endfunction

    // 1-based position to 0-based absolute index through the filter table
    function automatic int unsigned lookup_index(int unsigned d, int unsigned j,
                                                 inout logic err);
        int unsigned n;
        n = flen_eff(d);
        if (j == 0) begin
            err = 1'b1;
            return 0;
        end
        if (n == 0)
            return j - 1;
        if (j - 1 >= n) begin
            err = 1'b1;
            return 0;
        end
        return 32'(filter_mem[d][j-1]);
    endfunction

    // result owed for one accepted item; write items update the filter copy
    function automatic out_item_t predict_address(in_item_t it);
        int unsigned ndc, d, q, n_free, s, k, raw, ext, l;
        logic [63:0] pos;
        logic        err;
        out_item_t   r;
        r = '0;
        pos = '0;
        err = 1'b0;
        n_free = 0;
        if (it.command == CMD_FILTER_WR) begin
            filter_mem[it.filter_dim][it.filter_slot] = it.filter_value;
            return r;
        end
        ndc = dims_eff();
        // dimension 0 is most significant; stop at the first error
        for (d = 0; d < ndc && !err; d++) begin
            raw = mode_field(d);
            ext = extent_eff(d);
            l = 0;
            if (raw == 0) begin
                l = lookup_index(d, pick_input(it, n_free), err);
                n_free++;
            end else if (raw >= 512) begin
                // negative code: diagonal tie to another free dimension
                k = 1024 - raw;
                if (k > ndc || mode_field(k - 1) != 0) begin
                    err = 1'b1;
                end else begin
                    s = 0;
                    for (q = 0; q + 1 < k; q++)
                        if (mode_field(q) == 0)
                            s++;
                    l = lookup_index(k - 1, pick_input(it, s), err);
                end
            end else begin
                l = raw - 1;
            end
            if (l >= ext)
                err = 1'b1;
            pos = pos * ext + l;
        end
        r.range_error = err;
        r.offset      = err ? '0 : pos[OFFS_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // driver: one item per handshake, random gaps between items
    // ------------------------------------------------------------------

    always @(negedge clk) begin
        if (rst_n) begin
            if (!cmd_valid || cmd_fired) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
                    cmd_item  <= cmd_backlog.pop_front();
                    cmd_valid <= 1'b1;
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
            addr_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on accepted commands, check accepted results
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if (rst_n) begin
            cmd_fired <= cmd_valid && cmd_ready;
            if (cmd_valid && cmd_ready)
                predicted_addrs.insert(predicted_addrs.size(), predict_address(cmd_item));
            if (addr_valid && addr_ready) begin
                if (predicted_addrs.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result: expected none, got offset %h err %b",
                             $time, addr_item.offset, addr_item.range_error);
                end else if (predicted_addrs[0].offset != addr_item.offset ||
                             predicted_addrs[0].range_error != addr_item.range_error) begin
                    mismatch_count++;
                    $display("%0t: result mismatch: expected offset %h err %b, %s",
                             $time, predicted_addrs[0].offset, predicted_addrs[0].range_error,
                             $sformatf("got offset %h err %b",
                                       addr_item.offset, addr_item.range_error));
                    void'(predicted_addrs.pop_front());
                end else begin
                    void'(predicted_addrs.pop_front());
                end
            end
            // watchdog on handshake activity
            if ((cmd_valid && cmd_ready) || (addr_valid && addr_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // item with every field random, command given
    function automatic in_item_t random_item(logic cmd);
        in_item_t it;
        it.command      = cmd;
        it.index_a      = IDX_W'($urandom_range(511, 0));
        it.index_b      = IDX_W'($urandom_range(511, 0));
        it.index_c      = IDX_W'($urandom_range(511, 0));
        it.index_d      = IDX_W'($urandom_range(511, 0));
        it.filter_dim   = FDIM_W'($urandom_range(3, 0));
        it.filter_slot  = FSLOT_W'($urandom_range(255, 0));
        it.filter_value = FVAL_W'($urandom_range(255, 0));
        return it;
    endfunction

    // mostly in range so that deep dimensions get reached, sometimes any 9-bit value
    function automatic int unsigned pick_index(int unsigned bound);
        if ($urandom_range(99, 0) < 85)
            return $urandom_range(bound, 1);
        return $urandom_range(511, 0);
    endfunction

    // filter contents mostly below the current extent of that dimension
    function automatic int unsigned fill_value(int unsigned d);
        int unsigned e;
        e = extent_eff(d);
        if (e != 0 && $urandom_range(99, 0) < 80)
            return $urandom_range(e - 1, 0);
        return $urandom_range(255, 0);
    endfunction

    task automatic queue_filter_write(int unsigned d, int unsigned s, int unsigned v);
        in_item_t it;
        it = random_item(CMD_FILTER_WR);
        it.filter_dim   = FDIM_W'(d);
        it.filter_slot  = FSLOT_W'(s);
        it.filter_value = FVAL_W'(v);
        slot_planned[d][s] = 1'b1;
        cmd_backlog.insert(cmd_backlog.size(), it);
        items_queued++;
    endtask

    task automatic queue_compute_at(int unsigned a, int unsigned b, int unsigned c,
                                    int unsigned e);
        in_item_t it;
        it = random_item(CMD_COMPUTE);
        it.index_a = IDX_W'(a);
        it.index_b = IDX_W'(b);
        it.index_c = IDX_W'(c);
        it.index_d = IDX_W'(e);
        cmd_backlog.insert(cmd_backlog.size(), it);
        items_queued++;
    endtask

    // compute item whose indices mostly fit the dimensions they feed
    task automatic queue_compute();
        int unsigned bound[PACKED_DIMS];
        int unsigned d, n_free, sel, lim;
        for (d = 0; d < PACKED_DIMS; d++)
            bound[d] = MAX_EXTENT;
        n_free = 0;
        for (d = 0; d < dims_eff(); d++) begin
            if (mode_field(d) == 0) begin
                sel = 32'(perm_q[PERM_W*(n_free % PACKED_DIMS) +: PERM_W]);
                lim = (flen_eff(d) != 0) ? flen_eff(d) : extent_eff(d);
                if (lim == 0)
                    lim = 1;
                if (lim < bound[sel])
                    bound[sel] = lim;
                n_free++;
            end
        end
        queue_compute_at(pick_index(bound[0]), pick_index(bound[1]),
                         pick_index(bound[2]), pick_index(bound[3]));
    endtask

    // hold until the driver is empty and every owed result has come back
    task automatic drain();
        while (cmd_backlog.size() != 0 || cmd_valid || predicted_addrs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // setup cycle, then access cycle; the register lands on the edge that ends the access cycle
    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ACTIVE_DIMS: nd_q   = data[ND_W-1:0];
            REG_EXTENTS:     ext_q  = data[PACKED_DIMS*EXT_W-1:0];
            REG_INDEX_MODES: mode_q = data[PACKED_DIMS*MODE_W-1:0];
            REG_PERMUTATION: perm_q = data[PACKED_DIMS*PERM_W-1:0];
            REG_FILTER_LENS: flen_q = data[PACKED_DIMS*EXT_W-1:0];
            default: ;
        endcase
    endtask

    // new view on an idle block, then fill any filter slot it can read
    task automatic program_view(logic [ND_W-1:0] nd,
                                logic [PACKED_DIMS*EXT_W-1:0] ext,
                                logic [PACKED_DIMS*MODE_W-1:0] modes,
                                logic [PACKED_DIMS*PERM_W-1:0] perm,
                                logic [PACKED_DIMS*EXT_W-1:0] flens);
        int unsigned d, s;
        drain();
        apb_write(REG_ACTIVE_DIMS, PDATA_W'(nd));
        apb_write(REG_EXTENTS, PDATA_W'(ext));
        apb_write(REG_INDEX_MODES, PDATA_W'(modes));
        apb_write(REG_PERMUTATION, PDATA_W'(perm));
        apb_write(REG_FILTER_LENS, PDATA_W'(flens));
        for (d = 0; d < PACKED_DIMS; d++)
            for (s = 0; s < flen_eff(d); s++)
                if (!slot_planned[d][s])
                    queue_filter_write(d, s, fill_value(d));
    endtask

    // mostly sane views: small extents, free dims, valid ties, short filters
    task automatic random_view();
        logic [ND_W-1:0]               nd;
        logic [PACKED_DIMS*EXT_W-1:0]  ext, flens;
        logic [PACKED_DIMS*MODE_W-1:0] modes;
        int unsigned d, r, e, m, n;
        r = $urandom_range(19, 0);
        if (r == 0)
            nd = '0;
        else if (r == 1)
            nd = ND_W'($urandom_range(7, 5));
        else
            nd = ND_W'($urandom_range(4, 1));
        for (d = 0; d < PACKED_DIMS; d++) begin
            r = $urandom_range(19, 0);
            if (r == 0)
                e = 0;
            else if (r == 1)
                e = $urandom_range(511, 257);
            else if (r < 10)
                e = $urandom_range(8, 1);
            else
                e = $urandom_range(256, 1);
            ext[EXT_W*d +: EXT_W] = EXT_W'(e);
            if (e > MAX_EXTENT)
                e = MAX_EXTENT;
            r = $urandom_range(19, 0);
            if (r < 11)
                m = 0;
            else if (r < 15)
                m = $urandom_range((e == 0) ? 1 : e, 1);
            else if (r < 18)
                m = 1024 - $urandom_range(d + 1, 1);   // tie, self tie is a bad one
            else
                m = $urandom_range(1023, 0);
            modes[MODE_W*d +: MODE_W] = MODE_W'(m);
            r = $urandom_range(39, 0);
            if (r < 24)
                n = 0;
            else if (r < 39)
                n = $urandom_range(40, 1);
            else
                n = $urandom_range(511, 1);
            flens[EXT_W*d +: EXT_W] = EXT_W'(n);
        end
        program_view(nd, ext, modes, (PACKED_DIMS*PERM_W)'($urandom_range(255, 0)), flens);
    endtask

    task automatic run_random_phase();
        int unsigned i, n, d;
        n = $urandom_range(140, 60);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(99, 0) < 12) begin
                d = $urandom_range(3, 0);
                queue_filter_write(d, $urandom_range(255, 0), fill_value(d));
            end else begin
                queue_compute();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial begin
        int phase;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset view: one dimension of extent one, so only index one is legal
        queue_filter_write(0, 0, 0);
        queue_filter_write(3, 255, 255);
        queue_filter_write(2, 128, 8'h5a);
        queue_compute_at(1, 1, 1, 1);
        queue_compute_at(0, 511, 0, 511);
        queue_compute_at(2, 0, 0, 0);
        queue_compute_at(511, 1, 1, 1);

        // four full dimensions: largest offset, smallest, and a mixed one
        program_view(ND_W'(4), {4{9'd256}}, '0, PERM_RST, '0);
        queue_compute_at(256, 256, 256, 256);
        queue_compute_at(1, 1, 1, 1);
        queue_compute_at(2, 3, 4, 5);

        // fixed dim, valid diagonal tie, filtered dim 0, every slot reads index_a
        program_view(ND_W'(4), {9'd3, 9'd5, 9'd7, 9'd5}, {10'd0, 10'd1023, 10'd2, 10'd0},
                     8'h00, {27'd0, 9'd3});
        queue_compute_at(1, 9, 9, 9);
        queue_compute_at(3, 0, 0, 0);
        queue_compute_at(4, 1, 1, 1);
        queue_compute_at(0, 1, 1, 1);

        // scalar view: no dimensions, no error even with zero indices
        program_view(ND_W'(0), EXTENTS_RST, '0, PERM_RST, '0);
        queue_compute_at(0, 0, 0, 0);

        // zero extents and every mode a tie to dimension one
        program_view(ND_W'(4), '0, {4{10'h3ff}}, 8'hff, '0);
        queue_compute_at(1, 1, 1, 1);
        queue_compute_at(511, 511, 511, 511);

        // random phases; idling follows the thirds of the run
        phase = 0;
        while (items_queued < ITEM_TARGET) begin
            if (phase == 2)
                // saturated dim count, extents and dim 3 filter length
                program_view(ND_W'(7), {4{9'h1ff}}, '0,
                             (PACKED_DIMS*PERM_W)'($urandom_range(255, 0)), {9'h1ff, 27'd0});
            else
                random_view();
            if (items_queued < ITEM_TARGET / 3) begin
                sender_idle_pct    = 25;
                receiver_stall_pct = 65;
            end else if (items_queued < 2 * ITEM_TARGET / 3) begin
                sender_idle_pct    = 65;
                receiver_stall_pct = 25;
            end else begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            run_random_phase();
            phase++;
        end

        drain();
        if (mismatch_count == 0 && predicted_addrs.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
